[rtl/core/fvts_pkg.sv]
// Package for the four-voice tone sequencer: field types, command and register
// codes, mixer constants and the shared arithmetic unit's request/response types.
// No dependencies.
package fvts_pkg;

  // Payload field types
  typedef logic [2:0]  command_t;
  typedef logic [9:0]  addr_t;
  typedef logic [15:0] word_t;
  typedef logic [1:0]  track_t;
  typedef logic [7:0]  level_t;
  typedef logic [0:0]  cfg_idx_t;

  // Commands
  localparam command_t CMD_TICK     = 3'd0;
  localparam command_t CMD_SONG_WR  = 3'd1;
  localparam command_t CMD_FX_WR    = 3'd2;
  localparam command_t CMD_SONG_GO  = 3'd3;
  localparam command_t CMD_FX_GO    = 3'd4;
  localparam command_t CMD_SONG_END = 3'd5;

  // Configuration register indexes
  localparam cfg_idx_t CFG_SINGLE_CHANNEL = 1'd0;
  localparam cfg_idx_t CFG_REPEAT_SONG    = 1'd1;

  // Table words: song {delay, track, step}, effect {delay, step}
  localparam int SONG_WORD_W = 34;
  localparam int FX_WORD_W   = 32;

  localparam word_t END_MARK  = 16'hFFFF;
  localparam word_t TIMER_MAX = 16'hFFFF;

  localparam int     MUSIC_VOICES = 3;
  localparam track_t FX_VOICE     = 2'd3;

  // Mixer weights: 0x80 per half level, doubled normally, tripled in single mode
  localparam int         MIX_W      = 11;
  localparam logic [10:0] MIX_HALF   = 11'h080;
  localparam logic [10:0] MIX_NORMAL = MIX_HALF << 1;
  localparam logic [10:0] MIX_SINGLE = MIX_HALF * 11'd3;

  // Shared add/subtract unit
  localparam int ALU_W = 17;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             neg;
  } alu_rsp_t;

endpackage

[rtl/core/fvts_chan_if.sv]
// Request and result channel interfaces of the four-voice tone sequencer.
// Depends on fvts_pkg for the field types.
interface fvts_in_if import fvts_pkg::*; ();
  logic     valid;
  logic     ready;
  command_t command;
  addr_t    address;
  word_t    entry_delay;
  track_t   entry_track;
  word_t    entry_step;

  modport source (output valid, command, address, entry_delay, entry_track, entry_step,
                  input ready);
  modport sink   (input valid, command, address, entry_delay, entry_track, entry_step,
                  output ready);
endinterface

interface fvts_out_if import fvts_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t pwm_level;
  logic   song_active;
  logic   effect_active;

  modport source (output valid, pwm_level, song_active, effect_active, input ready);
  modport sink   (input valid, pwm_level, song_active, effect_active, output ready);
endinterface

[rtl/core/fvts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fvts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/fvts_alu.sv]
// Shared add/subtract unit: phase advance, timer compare, start address reduction.
// Depends on fvts_pkg for the request and response structs.
module fvts_alu import fvts_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W:0] opb;
  logic [ALU_W:0] sum;

  // a + b, or a - b with the sign in the top bit
  always_comb begin
    opb = req.sub ? ~{1'b0, req.b} : {1'b0, req.b};
    sum = {1'b0, req.a} + opb + (ALU_W+1)'(req.sub);
    rsp.res = sum[ALU_W-1:0];
    rsp.neg = sum[ALU_W];
  end

endmodule

[rtl/core/four_voice_tone_sequencer_top.sv]
// Four-voice tone sequencer top level: sequencer, voice registers, song and
// effect tables. Depends on fvts_pkg, fvts_chan_if, fvts_ram and fvts_alu.
//
//   port       dir  handshake          payload
//   in_ch      in   valid/ready        command, address, entry_delay, entry_track, entry_step
//   out_ch     out  valid/ready        pwm_level, song_active, effect_active
//   cfg_*      in   cfg_we only        cfg_index, cfg_wdata
//
// A tick runs through: accept, four phase adds through the shared adder, song
// compare and up to two song table reads, effect compare and up to one read,
// then the result load. Table writes and stop complete on acceptance. A start
// subtracts the table size from the address repeatedly, then loads the pointer.
// Reset is synchronous and active low; the tables are not cleared.
// A tick result waits in the output register; a later tick holds in its last
// step until that register frees; no request is accepted meanwhile.
module four_voice_tone_sequencer_top import fvts_pkg::*; #(
  parameter int SONG_ENTRIES = 1024,
  parameter int EFFECT_PAIRS = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  logic     cfg_wdata,
  fvts_in_if.sink    in_ch,
  fvts_out_if.source out_ch
);

  localparam int SPW = $clog2(SONG_ENTRIES);
  localparam int EPW = $clog2(EFFECT_PAIRS);
  localparam logic [SPW-1:0]   SONG_LAST = SPW'(SONG_ENTRIES - 1);
  localparam logic [EPW-1:0]   FX_LAST   = EPW'(EFFECT_PAIRS - 1);
  localparam logic [ALU_W-1:0] SONG_SIZE = ALU_W'(SONG_ENTRIES);
  localparam logic [ALU_W-1:0] FX_SIZE   = ALU_W'(EFFECT_PAIRS);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PH   = 3'd1;
  localparam logic [2:0] ST_SCMP = 3'd2;
  localparam logic [2:0] ST_SRD  = 3'd3;
  localparam logic [2:0] ST_ECMP = 3'd4;
  localparam logic [2:0] ST_ERD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;
  localparam logic [2:0] ST_MOD  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  track_t           voice_r, voice_nxt;
  logic             restart_r, restart_nxt;
  logic             mod_fx_r, mod_fx_nxt;
  logic [ALU_W-1:0] rem_r, rem_nxt;
  level_t           level_r, level_nxt;

  word_t            voice_phase_r [4];
  word_t            voice_phase_nxt [4];
  word_t            voice_step_r [4];
  word_t            voice_step_nxt [4];

  logic [SPW-1:0]   song_ptr_r, song_ptr_nxt;
  logic [SPW-1:0]   song_start_r, song_start_nxt;
  logic             song_play_r, song_play_nxt;
  word_t            song_wait_r, song_wait_nxt;
  word_t            song_timer_r, song_timer_nxt;
  logic [EPW-1:0]   fx_ptr_r, fx_ptr_nxt;
  logic             fx_play_r, fx_play_nxt;
  word_t            fx_wait_r, fx_wait_nxt;
  word_t            fx_timer_r, fx_timer_nxt;
  logic             single_r, single_nxt;
  logic             repeat_r, repeat_nxt;

  logic             out_valid_r, out_valid_nxt;
  level_t           out_level_r, out_level_nxt;
  logic             out_song_r, out_song_nxt;
  logic             out_fx_r, out_fx_nxt;

  logic                   in_fire;
  logic [ALU_W-1:0]       addr_ext;
  logic [MIX_W-1:0]       mix_sum;
  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;

  logic                   song_we;
  logic [SPW-1:0]         song_raddr;
  logic [SONG_WORD_W-1:0] song_rdata;
  logic                   fx_we;
  logic [FX_WORD_W-1:0]   fx_rdata;

  word_t                  sd_delay;
  track_t                 sd_track;
  word_t                  sd_step;
  logic [SPW-1:0]         sd_entry;
  word_t                  fd_delay;
  word_t                  fd_step;

  // Handshake
  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_fire           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pwm_level  = out_level_r;
  assign out_ch.song_active   = out_song_r;
  assign out_ch.effect_active = out_fx_r;

  assign addr_ext = ALU_W'(in_ch.address);

  // Table word fields
  assign sd_delay = song_rdata[33:18];
  assign sd_track = song_rdata[17:16];
  assign sd_step  = song_rdata[15:0];
  assign sd_entry = restart_r ? song_start_r : song_ptr_r;
  assign fd_delay = fx_rdata[31:16];
  assign fd_step  = fx_rdata[15:0];

  // Tables
  assign song_we = in_fire && (in_ch.command == CMD_SONG_WR) && (addr_ext < SONG_SIZE);
  assign fx_we   = in_fire && (in_ch.command == CMD_FX_WR) && (addr_ext < FX_SIZE);

  fvts_ram #(.WIDTH(SONG_WORD_W), .DEPTH(SONG_ENTRIES)) u_song_ram (
    .clk   (clk),
    .we    (song_we),
    .waddr (addr_ext[SPW-1:0]),
    .wdata ({in_ch.entry_delay, in_ch.entry_track, in_ch.entry_step}),
    .raddr (song_raddr),
    .rdata (song_rdata)
  );

  fvts_ram #(.WIDTH(FX_WORD_W), .DEPTH(EFFECT_PAIRS)) u_fx_ram (
    .clk   (clk),
    .we    (fx_we),
    .waddr (addr_ext[EPW-1:0]),
    .wdata ({in_ch.entry_delay, in_ch.entry_step}),
    .raddr (fx_ptr_r),
    .rdata (fx_rdata)
  );

  fvts_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Mixer: phases before this tick's advance
  always_comb begin
    mix_sum = MIX_W'(voice_phase_r[FX_VOICE][15:7]);
    if (single_r) begin
      if (voice_phase_r[0][15]) mix_sum = mix_sum + MIX_SINGLE;
    end else begin
      for (int v = 0; v < MUSIC_VOICES; v++) begin
        if (voice_phase_r[v][15]) mix_sum = mix_sum + MIX_NORMAL;
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    voice_nxt      = voice_r;
    restart_nxt    = restart_r;
    mod_fx_nxt     = mod_fx_r;
    rem_nxt        = rem_r;
    level_nxt      = level_r;
    voice_phase_nxt = voice_phase_r;
    voice_step_nxt  = voice_step_r;
    song_ptr_nxt   = song_ptr_r;
    song_start_nxt = song_start_r;
    song_play_nxt  = song_play_r;
    song_wait_nxt  = song_wait_r;
    song_timer_nxt = song_timer_r;
    fx_ptr_nxt     = fx_ptr_r;
    fx_play_nxt    = fx_play_r;
    fx_wait_nxt    = fx_wait_r;
    fx_timer_nxt   = fx_timer_r;
    single_nxt     = single_r;
    repeat_nxt     = repeat_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_level_nxt  = out_level_r;
    out_song_nxt   = out_song_r;
    out_fx_nxt     = out_fx_r;
    alu_req        = '0;
    song_raddr     = song_ptr_r;

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_SINGLE_CHANNEL: single_nxt = cfg_wdata;
        CFG_REPEAT_SONG:    repeat_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.command)
            CMD_TICK: begin
              level_nxt = mix_sum[9:2];
              if (song_timer_r != TIMER_MAX) song_timer_nxt = song_timer_r + 16'd1;
              if (fx_timer_r != TIMER_MAX) fx_timer_nxt = fx_timer_r + 16'd1;
              voice_nxt = '0;
              state_nxt = ST_PH;
            end
            CMD_SONG_GO: begin
              song_wait_nxt = '0;
              song_play_nxt = 1'b1;
              for (int v = 0; v < MUSIC_VOICES; v++) begin
                voice_phase_nxt[v] = '0;
                voice_step_nxt[v]  = '0;
              end
              rem_nxt    = addr_ext;
              mod_fx_nxt = 1'b0;
              state_nxt  = ST_MOD;
            end
            CMD_FX_GO: begin
              fx_wait_nxt = '0;
              fx_play_nxt = 1'b1;
              rem_nxt     = addr_ext;
              mod_fx_nxt  = 1'b1;
              state_nxt   = ST_MOD;
            end
            CMD_SONG_END: begin
              song_play_nxt = 1'b0;
              for (int v = 0; v < MUSIC_VOICES; v++) begin
                voice_phase_nxt[v] = '0;
                voice_step_nxt[v]  = '0;
              end
            end
            default: ;
          endcase
        end
      end

      // Start address modulo table size by repeated subtraction
      ST_MOD: begin
        alu_req.a   = rem_r;
        alu_req.b   = mod_fx_r ? FX_SIZE : SONG_SIZE;
        alu_req.sub = 1'b1;
        if (!alu_rsp.neg) begin
          rem_nxt = alu_rsp.res;
        end else begin
          if (mod_fx_r) begin
            fx_ptr_nxt = rem_r[EPW-1:0];
          end else begin
            song_start_nxt = rem_r[SPW-1:0];
            song_ptr_nxt   = rem_r[SPW-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end

      // One phase add per cycle; voices 1 and 2 hold in single mode
      ST_PH: begin
        alu_req.a = {1'b0, voice_phase_r[voice_r]};
        alu_req.b = {1'b0, voice_step_r[voice_r]};
        if (!(single_r && (voice_r == 2'd1 || voice_r == 2'd2))) begin
          voice_phase_nxt[voice_r] = alu_rsp.res[15:0];
        end
        if (voice_r == FX_VOICE) begin
          state_nxt = ST_SCMP;
        end else begin
          voice_nxt = voice_r + 2'd1;
        end
      end

      // Song due when timer > wait; table read at the pointer goes out now
      ST_SCMP: begin
        alu_req.a   = {1'b0, song_wait_r};
        alu_req.b   = {1'b0, song_timer_r};
        alu_req.sub = 1'b1;
        restart_nxt = 1'b0;
        if (song_play_r && alu_rsp.neg) begin
          state_nxt = ST_SRD;
        end else begin
          state_nxt = ST_ECMP;
        end
      end

      ST_SRD: begin
        if (sd_delay == END_MARK) begin
          if (!repeat_r || restart_r) begin
            song_play_nxt = 1'b0;
            for (int v = 0; v < MUSIC_VOICES; v++) begin
              voice_phase_nxt[v] = '0;
              voice_step_nxt[v]  = '0;
            end
            restart_nxt = 1'b0;
            state_nxt   = ST_ECMP;
          end else begin
            // end marker with repeat: read the start entry next
            song_raddr  = song_start_r;
            restart_nxt = 1'b1;
          end
        end else begin
          song_timer_nxt = '0;
          song_wait_nxt  = sd_delay;
          if (sd_track < track_t'(MUSIC_VOICES)) voice_step_nxt[sd_track] = sd_step;
          song_ptr_nxt = (sd_entry == SONG_LAST) ? '0 : sd_entry + SPW'(1);
          restart_nxt  = 1'b0;
          state_nxt    = ST_ECMP;
        end
      end

      ST_ECMP: begin
        alu_req.a   = {1'b0, fx_wait_r};
        alu_req.b   = {1'b0, fx_timer_r};
        alu_req.sub = 1'b1;
        if (fx_play_r && alu_rsp.neg) begin
          state_nxt = ST_ERD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_ERD: begin
        fx_timer_nxt = '0;
        fx_wait_nxt  = fd_delay;
        if (fd_delay == END_MARK) begin
          fx_play_nxt               = 1'b0;
          voice_step_nxt[FX_VOICE]  = '0;
          voice_phase_nxt[FX_VOICE] = '0;
        end else begin
          voice_step_nxt[FX_VOICE] = fd_step;
        end
        fx_ptr_nxt = (fx_ptr_r == FX_LAST) ? '0 : fx_ptr_r + EPW'(1);
        state_nxt  = ST_DONE;
      end

      // Load the result once the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = level_r;
          out_song_nxt  = song_play_r;
          out_fx_nxt    = fx_play_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      voice_r      <= '0;
      restart_r    <= 1'b0;
      mod_fx_r     <= 1'b0;
      for (int v = 0; v < 4; v++) begin
        voice_phase_r[v] <= '0;
        voice_step_r[v]  <= '0;
      end
      song_ptr_r   <= '0;
      song_start_r <= '0;
      song_play_r  <= 1'b0;
      song_wait_r  <= '0;
      song_timer_r <= '0;
      fx_ptr_r     <= '0;
      fx_play_r    <= 1'b0;
      fx_wait_r    <= '0;
      fx_timer_r   <= '0;
      single_r     <= 1'b0;
      repeat_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      voice_r      <= voice_nxt;
      restart_r    <= restart_nxt;
      mod_fx_r     <= mod_fx_nxt;
      voice_phase_r <= voice_phase_nxt;
      voice_step_r  <= voice_step_nxt;
      song_ptr_r   <= song_ptr_nxt;
      song_start_r <= song_start_nxt;
      song_play_r  <= song_play_nxt;
      song_wait_r  <= song_wait_nxt;
      song_timer_r <= song_timer_nxt;
      fx_ptr_r     <= fx_ptr_nxt;
      fx_play_r    <= fx_play_nxt;
      fx_wait_r    <= fx_wait_nxt;
      fx_timer_r   <= fx_timer_nxt;
      single_r     <= single_nxt;
      repeat_r     <= repeat_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    level_r     <= level_nxt;
    out_level_r <= out_level_nxt;
    out_song_r  <= out_song_nxt;
    out_fx_r    <= out_fx_nxt;
  end

endmodule
